FILE: rtl/cell_charge_curve_estimator_core_assert.svh
// ----------------------------------------------------------------------------
// Charge curve estimator assertion macros
// Concurrent check shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CELL_CHARGE_CURVE_ESTIMATOR_CORE_ASSERT_SVH
`define CELL_CHARGE_CURVE_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define CCCE_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccce: same-cycle check failed");

// Next-cycle implication.
`define CCCE_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccce: next-cycle check failed");

`endif

FILE: rtl/ccce_pkg.sv
// ----------------------------------------------------------------------------
// ccce_pkg
// Widths, register codes, curve constants and unit control types.
// ----------------------------------------------------------------------------
`default_nettype none

package ccce_pkg;

    localparam int MV_W       = 16;
    localparam int CAP_W      = 24;
    localparam int CELLS_W    = 3;
    localparam int PCT_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RATED_MV      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_MV  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_PACK = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PACK_CAPACITY = 4'd3;

    localparam logic [MV_W-1:0]    RATED_RST     = 16'd4200;
    localparam logic [MV_W-1:0]    DISCHARGE_RST = 16'd3000;
    localparam logic [CELLS_W-1:0] CELLS_RST     = 3'd4;
    localparam logic [CAP_W-1:0]   CAPACITY_RST  = 24'd0;

    // Level in Q3.16, 0 .. 4.0
    localparam int                LEVEL_W    = 19;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 19'd262144;
    // Curve rewritten as Y = 2x((x - 0.75)^2 + 7/16), all terms in Q.16 / Q.32
    localparam logic [LEVEL_W-1:0] CURVE_KNEE = 19'd49152;

    localparam logic [PCT_W-1:0] PCT_FULL_SCALE = 16'd20000;
    localparam logic [PCT_W-1:0] PCT_SAT        = 16'hFFFF;

    // Shared shift-add multiplier
    localparam int MUL_A_W   = 36;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 6;

    localparam logic [MUL_A_W-1:0]   CURVE_OFS = 36'd1879048192;
    localparam logic [MUL_B_W-1:0]   PCT_SCALE = 32'd10000;
    localparam logic [MUL_CNT_W-1:0] N_MUL_X   = 6'd14;
    localparam logic [MUL_CNT_W-1:0] N_MUL_D   = 6'd18;
    localparam logic [MUL_CNT_W-1:0] N_MUL_Y   = 6'd32;
    localparam logic [MUL_CNT_W-1:0] N_MUL_C   = 6'd16;

    // Shared restoring divider
    localparam int DIV_W      = 16;
    localparam int DIV_BITS_W = 27;
    localparam int DIV_CNT_W  = 5;

    localparam logic [DIV_CNT_W-1:0] N_DIV_LVL   = 5'd18;
    localparam logic [DIV_CNT_W-1:0] N_DIV_EST   = 5'd27;
    localparam logic [DIV_W-1:0]     EST_DIVISOR = 16'd10000;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] count;
    } mul_req_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ccce_if.sv
// ----------------------------------------------------------------------------
// ccce channel interfaces
// Valid/ready channels for cell beats, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccce_cell_if;
    import ccce_pkg::*;
    logic             valid;
    logic             ready;
    logic [MV_W-1:0]  cell_mv;
    logic [CAP_W-1:0] remaining_in;
    modport source (output valid, cell_mv, remaining_in, input ready);
    modport sink   (input valid, cell_mv, remaining_in, output ready);
endinterface

interface ccce_result_if;
    import ccce_pkg::*;
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] cell_percent;
    logic             pack_done;
    logic [CAP_W-1:0] remaining_out;
    modport source (output valid, cell_percent, pack_done, remaining_out, input ready);
    modport sink   (input valid, cell_percent, pack_done, remaining_out, output ready);
endinterface

interface ccce_cfg_if;
    import ccce_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ccce_mul.sv
// ----------------------------------------------------------------------------
// ccce_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module ccce_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ccce_pkg::mul_req_t              req,
    input  logic [ccce_pkg::MUL_A_W-1:0]    a_in,
    input  logic [ccce_pkg::MUL_B_W-1:0]    b_in,
    output ccce_pkg::unit_stat_t            stat,
    output logic [ccce_pkg::MUL_P_W-1:0]    prod
);
    import ccce_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_A_W-1:0]   acc_reg;
    logic [MUL_B_W-1:0]   low_reg;
    logic [MUL_A_W:0]     sum;

    assign sum = {1'b0, acc_reg} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Retire one product bit into the low word each step
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
            low_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum[MUL_A_W:1];
            low_reg <= {sum[0], low_reg[MUL_B_W-1:1]};
            b_reg   <= b_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = {acc_reg, low_reg};

endmodule

`default_nettype wire

FILE: rtl/ccce_div.sv
// ----------------------------------------------------------------------------
// ccce_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccce_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ccce_pkg::div_req_t                req,
    input  logic [ccce_pkg::DIV_W-1:0]        rem_in,
    input  logic [ccce_pkg::DIV_BITS_W-1:0]   bits_in,
    input  logic [ccce_pkg::DIV_W-1:0]        divisor,
    output ccce_pkg::unit_stat_t              stat,
    output logic [ccce_pkg::DIV_BITS_W-1:0]   quo
);
    import ccce_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      dvs_reg;
    logic [DIV_BITS_W-1:0] bits_reg;
    logic [DIV_BITS_W-1:0] quo_reg;
    logic [DIV_W:0]        shifted;
    logic [DIV_W:0]        diff;
    logic                  ge;

    assign shifted = {rem_reg, bits_reg[DIV_BITS_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder stays below the divisor, so it fits back in DIV_W bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= rem_in;
            dvs_reg  <= divisor;
            bits_reg <= bits_in;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            bits_reg <= bits_reg << 1;
            quo_reg  <= {quo_reg[DIV_BITS_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/cell_charge_curve_estimator_core.sv
// ----------------------------------------------------------------------------
// cell_charge_curve_estimator_core
// Cell voltage to charge percent on a cubic curve, with pack minimum tracking
// and remaining-capacity update on the pack's last cell.
// ----------------------------------------------------------------------------
//
//  channel     dir   handshake      payload
//  ---------   ---   ------------   ---------------------------------------
//  cell_ch     in    valid/ready    cell_mv[15:0], remaining_in[23:0]
//  result_ch   out   valid/ready    cell_percent[15:0], pack_done,
//                                   remaining_out[23:0]
//  cfg         in    valid/ready    index[3:0], data[23:0] (ready tied high)
//
//  From accept to result, one cell beat passes the level divider, then the
//  serial multiplier for the scaled level, the squared knee distance and the
//  curve product, plus entry and exit states. A level that is floored or
//  saturated skips the divider. The pack's last cell adds a capacity multiply
//  and a divide by 10000. A new beat is taken as soon as the previous result
//  sits in the output register; a stalled result holds only that register.
//  Reset is asynchronous, active low, and loads the register defaults.
//
`default_nettype none
`include "cell_charge_curve_estimator_core_assert.svh"

module cell_charge_curve_estimator_core #(
    parameter int MAX_CELLS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    ccce_cell_if.sink         cell_ch,
    ccce_result_if.source     result_ch,
    ccce_cfg_if.sink          cfg
);
    import ccce_pkg::*;

    localparam int PW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W = ((PW > CELLS_W) ? PW : CELLS_W) + 1;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LEVEL   = 9'b000000010,
        S_DIV_LVL = 9'b000000100,
        S_MUL_X   = 9'b000001000,
        S_MUL_D   = 9'b000010000,
        S_MUL_Y   = 9'b000100000,
        S_MUL_C   = 9'b001000000,
        S_DIV_EST = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    // Registers
    state_t              state_reg, state_next;
    logic [MV_W-1:0]     rated_reg;
    logic [MV_W-1:0]     dis_reg;
    logic [CELLS_W-1:0]  cells_reg;
    logic [CAP_W-1:0]    cap_reg;

    logic [PW-1:0]       pos_reg, pos_next;
    logic [PCT_W-1:0]    lowest_reg, lowest_next;
    logic [PCT_W-1:0]    first_reg, first_next;

    logic [MV_W-1:0]     mv_reg, mv_next;
    logic [CAP_W-1:0]    rem_in_reg, rem_in_next;
    logic [LEVEL_W-1:0]  x_reg, x_next;
    logic [MUL_B_W-1:0]  x10k_reg, x10k_next;
    logic [PCT_W-1:0]    pct_reg, pct_next;
    logic                last_reg, last_next;
    logic [CAP_W-1:0]    rem_out_reg, rem_out_next;

    logic                out_valid_reg, out_valid_next;
    logic [PCT_W-1:0]    out_pct_reg;
    logic                out_done_reg;
    logic [CAP_W-1:0]    out_rem_reg;

    // Unit hookup
    mul_req_t               mul_req;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    unit_stat_t             mul_stat;
    logic [MUL_P_W-1:0]     mul_prod;

    div_req_t               div_req;
    logic [DIV_W-1:0]       div_rem;
    logic [DIV_BITS_W-1:0]  div_bits;
    logic [DIV_W-1:0]       div_divisor;
    unit_stat_t             div_stat;
    logic [DIV_BITS_W-1:0]  div_quo;

    // Datapath taps
    logic                cell_accept;
    logic                out_load;
    logic [MV_W-1:0]     lvl;
    logic [MV_W-1:0]     span;
    logic                lvl_sat;
    logic [LEVEL_W-1:0]  knee_diff;
    logic [LEVEL_W-2:0]  absd;
    logic [MUL_A_W-1:0]  a_val;
    logic [20:0]         pct_wide;
    logic [PCT_W-1:0]    pct_val;
    logic [PCT_W-1:0]    lowest_val;
    logic [PCT_W-1:0]    first_val;
    logic [PCT_W-1:0]    use_val;
    logic [CNT_W-1:0]    count_eff;
    logic                last_val;

    ccce_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    ccce_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .rem_in  (div_rem),
        .bits_in (div_bits),
        .divisor (div_divisor),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    assign cell_accept = cell_ch.valid && cell_ch.ready;
    assign out_load    = (state_reg == S_OUT) && (!out_valid_reg || result_ch.ready);

    // Level: (mv - discharge) << 16 / span, saturating at four spans
    assign lvl     = mv_reg - dis_reg;
    assign span    = rated_reg - dis_reg;
    assign lvl_sat = {2'b00, lvl} >= {span, 2'b00};

    // Distance from the curve's knee at 0.75
    assign knee_diff = (x_reg >= CURVE_KNEE) ? (x_reg - CURVE_KNEE) : (CURVE_KNEE - x_reg);
    assign absd      = knee_diff[LEVEL_W-2:0];

    // Product slices: the multiplier leaves prod << (MUL_B_W - count)
    // d^2 at [49:14], then add 7/16 in Q.32
    assign a_val = mul_prod[49:14] + CURVE_OFS;

    // 10000 * x * a >> 47 is the percent in hundredths
    assign pct_wide = mul_prod[67:47];
    assign pct_val  = (|pct_wide[20:16]) ? PCT_SAT : pct_wide[15:0];

    // Running strict minimum, first-cell fallback
    assign lowest_val = (pct_val < lowest_reg) ? pct_val : lowest_reg;
    assign first_val  = (pos_reg == '0) ? pct_val : first_reg;
    assign use_val    = (lowest_val < PCT_FULL_SCALE) ? lowest_val : first_val;

    // Clamp the cell count to 1 .. MAX_CELLS
    always_comb
    begin
        if (cells_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (CNT_W'(cells_reg) > CNT_W'(MAX_CELLS))
        begin
            count_eff = CNT_W'(MAX_CELLS);
        end
        else
        begin
            count_eff = CNT_W'(cells_reg);
        end
    end

    assign last_val = (CNT_W'(pos_reg) + CNT_W'(1)) >= count_eff;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        mv_next      = mv_reg;
        rem_in_next  = rem_in_reg;
        x_next       = x_reg;
        x10k_next    = x10k_reg;
        pct_next     = pct_reg;
        last_next    = last_reg;
        rem_out_next = rem_out_reg;
        pos_next     = pos_reg;
        lowest_next  = lowest_reg;
        first_next   = first_reg;
        mul_req      = '0;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;
        div_rem      = '0;
        div_bits     = '0;
        div_divisor  = span;

        case (state_reg)
            S_IDLE:
            begin
                if (cell_accept)
                begin
                    mv_next     = cell_ch.cell_mv;
                    rem_in_next = cell_ch.remaining_in;
                    state_next  = S_LEVEL;
                end
            end

            S_LEVEL:
            begin
                if ((mv_reg <= dis_reg) || (rated_reg < dis_reg) ||
                    (rated_reg == dis_reg) || lvl_sat)
                begin
                    // Floor at empty, saturate at four spans or on zero span
                    if ((mv_reg <= dis_reg) || (rated_reg < dis_reg))
                    begin
                        x_next = '0;
                    end
                    else
                    begin
                        x_next = LEVEL_MAX;
                    end
                    mul_req.start = 1'b1;
                    mul_req.count = N_MUL_X;
                    mul_a         = MUL_A_W'(x_next);
                    mul_b         = PCT_SCALE;
                    state_next    = S_MUL_X;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.count = N_DIV_LVL;
                    div_rem       = DIV_W'(lvl[MV_W-1:2]);
                    div_bits      = {lvl[1:0], {(DIV_BITS_W-2){1'b0}}};
                    div_divisor   = span;
                    state_next    = S_DIV_LVL;
                end
            end

            S_DIV_LVL:
            begin
                if (div_stat.done)
                begin
                    x_next        = LEVEL_W'(div_quo[17:0]);
                    mul_req.start = 1'b1;
                    mul_req.count = N_MUL_X;
                    mul_a         = MUL_A_W'(x_next);
                    mul_b         = PCT_SCALE;
                    state_next    = S_MUL_X;
                end
            end

            S_MUL_X:
            begin
                if (mul_stat.done)
                begin
                    x10k_next     = mul_prod[49:18];
                    mul_req.start = 1'b1;
                    mul_req.count = N_MUL_D;
                    mul_a         = MUL_A_W'(absd);
                    mul_b         = MUL_B_W'(absd);
                    state_next    = S_MUL_D;
                end
            end

            S_MUL_D:
            begin
                if (mul_stat.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.count = N_MUL_Y;
                    mul_a         = a_val;
                    mul_b         = x10k_reg;
                    state_next    = S_MUL_Y;
                end
            end

            S_MUL_Y:
            begin
                if (mul_stat.done)
                begin
                    pct_next     = pct_val;
                    last_next    = last_val;
                    rem_out_next = rem_in_reg;
                    if (last_val)
                    begin
                        // Close the scan and estimate from the pack total
                        pos_next      = '0;
                        lowest_next   = PCT_FULL_SCALE;
                        first_next    = '0;
                        mul_req.start = 1'b1;
                        mul_req.count = N_MUL_C;
                        mul_a         = MUL_A_W'(cap_reg);
                        mul_b         = MUL_B_W'(use_val);
                        state_next    = S_MUL_C;
                    end
                    else
                    begin
                        pos_next    = pos_reg + PW'(1);
                        lowest_next = lowest_val;
                        first_next  = first_val;
                        state_next  = S_OUT;
                    end
                end
            end

            S_MUL_C:
            begin
                if (mul_stat.done)
                begin
                    // capacity * use sits at [55:16]; its top bits seed the remainder
                    div_req.start = 1'b1;
                    div_req.count = N_DIV_EST;
                    div_rem       = DIV_W'(mul_prod[55:43]);
                    div_bits      = mul_prod[42:16];
                    div_divisor   = EST_DIVISOR;
                    state_next    = S_DIV_EST;
                end
            end

            S_DIV_EST:
            begin
                if (div_stat.done)
                begin
                    if (div_quo < DIV_BITS_W'(rem_in_reg))
                    begin
                        rem_out_next = div_quo[CAP_W-1:0];
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            lowest_reg    <= PCT_FULL_SCALE;
            first_reg     <= '0;
            rated_reg     <= RATED_RST;
            dis_reg       <= DISCHARGE_RST;
            cells_reg     <= CELLS_RST;
            cap_reg       <= CAPACITY_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            lowest_reg    <= lowest_next;
            first_reg     <= first_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_RATED_MV:      rated_reg <= cfg.data[MV_W-1:0];
                    REG_DISCHARGE_MV:  dis_reg   <= cfg.data[MV_W-1:0];
                    REG_CELLS_IN_PACK: cells_reg <= cfg.data[CELLS_W-1:0];
                    REG_PACK_CAPACITY: cap_reg   <= cfg.data[CAP_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        mv_reg      <= mv_next;
        rem_in_reg  <= rem_in_next;
        x_reg       <= x_next;
        x10k_reg    <= x10k_next;
        pct_reg     <= pct_next;
        last_reg    <= last_next;
        rem_out_reg <= rem_out_next;
        if (out_load)
        begin
            out_pct_reg  <= pct_reg;
            out_done_reg <= last_reg;
            out_rem_reg  <= rem_out_reg;
        end
    end

    assign cfg.ready               = 1'b1;
    assign cell_ch.ready           = (state_reg == S_IDLE);
    assign result_ch.valid         = out_valid_reg;
    assign result_ch.cell_percent  = out_pct_reg;
    assign result_ch.pack_done     = out_done_reg;
    assign result_ch.remaining_out = out_rem_reg;

    // Checks
    `CCCE_CHECK_NEXT(a_accept_starts_level, cell_accept, state_reg == S_LEVEL)
    `CCCE_CHECK_IMP(a_one_unit_busy, mul_stat.busy, !div_stat.busy)
    `CCCE_CHECK_NEXT(a_result_only_from_out, !out_valid_reg && (state_reg != S_OUT), !out_valid_reg)
    `CCCE_CHECK_IMP(a_position_in_range, 1'b1, CNT_W'(pos_reg) < CNT_W'(MAX_CELLS))

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the charge curve estimator core. Cell beats go in
// under several register settings while both sides idle and stall at random.
// Each result is checked in order against a predictor of the charge curve
// and of the pack's minimum and remaining-capacity tracking.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccce_pkg::*;

    localparam int MAX_CELLS       = 4;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES     = 700;     // long result stall, fills the core
    localparam int SETTLE_CYCLES   = 8;       // idle margin before a register write
    localparam int DRAIN_CYCLES    = 200;
    localparam int PHASES          = 8;
    localparam int BEATS_PER_PHASE = 75;
    localparam int PRINT_LIMIT     = 40;
    localparam int PCT_DIVISOR     = 10000;
    localparam int LEVEL_HALF      = 32768;   // 0.5 in Q.16

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;
    localparam logic [CAP_W-1:0]     CAP_MAX       = '1;
    localparam logic [MV_W-1:0]      MV_MAX        = '1;
    localparam logic [CELLS_W-1:0]   CELLS_TOP     = '1;

    typedef struct packed {
        logic [PCT_W-1:0] cell_percent;
        logic             pack_done;
        logic [CAP_W-1:0] remaining_out;
    } cell_result_t;

    // ------------------------------------------------------------------------
    // Charge scoreboard: register copy, scan state and the queue of results
    // still owed by the core.
    // ------------------------------------------------------------------------
    class charge_scoreboard;
        logic [MV_W-1:0]    rated_mv;
        logic [MV_W-1:0]    discharge_mv;
        logic [CELLS_W-1:0] cells_in_pack;
        logic [CAP_W-1:0]   capacity;
        int                 position;
        logic [PCT_W-1:0]   lowest_pct;
        logic [PCT_W-1:0]   first_pct;
        cell_result_t       owed[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            rated_mv      = RATED_RST;
            discharge_mv  = DISCHARGE_RST;
            cells_in_pack = CELLS_RST;
            capacity      = CAPACITY_RST;
            position      = 0;
            lowest_pct    = PCT_FULL_SCALE;
            first_pct     = '0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RATED_MV:      rated_mv      = data[MV_W-1:0];
                REG_DISCHARGE_MV:  discharge_mv  = data[MV_W-1:0];
                REG_CELLS_IN_PACK: cells_in_pack = data[CELLS_W-1:0];
                REG_PACK_CAPACITY: capacity      = data[CAP_W-1:0];
                default: ;
            endcase
        endfunction

        // Level in Q3.16: floored at empty, saturated at four spans
        function logic [LEVEL_W-1:0] cell_level(logic [MV_W-1:0] mv);
            logic [63:0] quotient;
            if (mv <= discharge_mv)
                return '0;
            if (rated_mv == discharge_mv)
                return LEVEL_MAX;
            if (rated_mv < discharge_mv)
                return '0;
            quotient = (64'(mv - discharge_mv) << 16) / 64'(rated_mv - discharge_mv);
            return (quotient > 64'(LEVEL_MAX)) ? LEVEL_MAX : quotient[LEVEL_W-1:0];
        endfunction

        // Cubic curve held exactly at 2^48 scale, then hundredths of a percent
        function logic [PCT_W-1:0] curve_pct(logic [LEVEL_W-1:0] level);
            longint       t;
            longint       y;
            logic [127:0] scaled;
            t = longint'({45'd0, level}) - LEVEL_HALF;
            y = 2 * t * t * t + t * (longint'(1) << 31) + (longint'(1) << 47);
            if (y <= 0)
                return '0;
            scaled = y;
            scaled = (scaled * PCT_DIVISOR) >> 48;
            return (scaled > 128'(PCT_SAT)) ? PCT_SAT : scaled[PCT_W-1:0];
        endfunction

        function void note_cell(logic [MV_W-1:0] mv, logic [CAP_W-1:0] remaining);
            int           count;
            logic [PCT_W-1:0] pct;
            logic [PCT_W-1:0] basis;
            logic [63:0]  estimate;
            cell_result_t res;
            count = (cells_in_pack == '0) ? 1 : int'(cells_in_pack);
            if (count > MAX_CELLS)
                count = MAX_CELLS;
            pct = curve_pct(cell_level(mv));
            if (position == 0)
                first_pct = pct;
            if (pct < lowest_pct)
                lowest_pct = pct;
            res.cell_percent  = pct;
            res.pack_done     = (position + 1 >= count);
            res.remaining_out = remaining;
            if (res.pack_done) begin
                basis    = (lowest_pct < PCT_FULL_SCALE) ? lowest_pct : first_pct;
                estimate = (64'(capacity) * 64'(basis)) / PCT_DIVISOR;
                if (estimate < 64'(remaining))
                    res.remaining_out = estimate[CAP_W-1:0];
                position   = 0;
                lowest_pct = PCT_FULL_SCALE;
                first_pct  = '0;
            end
            else begin
                position++;
            end
            owed.push_back(res);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [PCT_W-1:0] pct, logic done, logic [CAP_W-1:0] remaining);
            cell_result_t want;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: pct %0d done %0b rem %0d",
                                          pct, done, remaining));
                return;
            end
            want = owed.pop_front();
            if (pct !== want.cell_percent || done !== want.pack_done
                    || remaining !== want.remaining_out)
                report_mismatch($sformatf(
                    "result %0d: pct %0d/%0d done %0b/%0b rem %0d/%0d (got/want)",
                    results_seen, pct, want.cell_percent, done, want.pack_done,
                    remaining, want.remaining_out));
            results_seen++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic src_idling;
    logic sink_idling;
    logic hold_asked;

    charge_scoreboard board = new();

    ccce_cell_if   cell_bus();
    ccce_result_if result_bus();
    ccce_cfg_if    cfg_bus();

    cell_charge_curve_estimator_core #(
        .MAX_CELLS (MAX_CELLS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_ch   (cell_bus),
        .result_ch (result_bus),
        .cfg       (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("watchdog expired after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off on request so
    // the core's single output register fills and the cell channel backs up.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int  stall_left;
        logic hold_taken;
        stall_left       = 0;
        hold_taken       = 1'b0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked && !hold_taken) begin
                hold_taken       = 1'b1;
                result_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left > 0)
                stall_left--;
            else if (sink_idling && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 13);
            result_bus.ready = (stall_left == 0);
        end
    end

    // Sample result beats at the rising edge and check them in order
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            board.check_result(result_bus.cell_percent, result_bus.pack_done,
                               result_bus.remaining_out);
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one cell beat, after an optional idle burst; note it once taken
    task automatic send_cell(input logic [MV_W-1:0] mv, input logic [CAP_W-1:0] remaining);
        int gap;
        if (src_idling && $urandom_range(0, 5) == 0) begin
            gap            = $urandom_range(1, 13);
            cell_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_bus.valid        = 1'b1;
        cell_bus.cell_mv      = mv;
        cell_bus.remaining_in = remaining;
        do @(posedge clk); while (!cell_bus.ready);
        board.note_cell(mv, remaining);
        @(negedge clk);
        // drop valid; a following send raises it again in this same step
        cell_bus.valid = 1'b0;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge clk); while (!cfg_bus.ready);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Hold the sender until every owed result is back, then settle
    task automatic drain_results();
        while (board.owed.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all four registers while idle, with junk in the unused upper
    // data bits, and finish with a write to an index that does nothing
    task automatic set_config(input logic [MV_W-1:0] rated, input logic [MV_W-1:0] discharge,
                              input logic [CELLS_W-1:0] cells, input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_write(REG_RATED_MV, {(CFG_DATA_W-MV_W)'($urandom), rated});
        cfg_write(REG_DISCHARGE_MV, {(CFG_DATA_W-MV_W)'($urandom), discharge});
        cfg_write(REG_CELLS_IN_PACK, {(CFG_DATA_W-CELLS_W)'($urandom), cells});
        cfg_write(REG_PACK_CAPACITY, cap);
        cfg_write(CFG_IDX_W'($urandom_range(REG_PACK_CAPACITY + 1, REG_INDEX_TOP)),
                  CFG_DATA_W'($urandom));
    endtask

    function automatic logic [MV_W-1:0] clip_mv(int v);
        if (v < 0)
            return '0;
        if (v > int'(MV_MAX))
            return MV_MAX;
        return MV_W'(v);
    endfunction

    // Voltages mostly across the live part of the curve, some pinned to the
    // span ends, repeats for ties, and some anywhere in the field
    function automatic logic [MV_W-1:0] pick_mv(logic [MV_W-1:0] previous);
        int span;
        int jitter;
        int choice;
        span   = (board.rated_mv > board.discharge_mv)
                 ? int'(board.rated_mv) - int'(board.discharge_mv) : 1200;
        jitter = $urandom_range(0, 4);
        jitter = jitter - 2;
        choice = $urandom_range(0, 99);
        if (choice < 55)
            return clip_mv(int'(board.discharge_mv) + int'($urandom_range(0, span + span / 2)));
        if (choice < 63)
            return clip_mv(int'(board.discharge_mv) + jitter);
        if (choice < 71)
            return clip_mv(int'(board.rated_mv) + jitter);
        if (choice < 81)
            return previous;
        if (choice < 88) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return MV_MAX;
                2:       return board.discharge_mv;
                default: return board.rated_mv;
            endcase
        end
        return MV_W'($urandom);
    endfunction

    function automatic logic [CAP_W-1:0] pick_remaining();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return CAP_MAX;
            2, 3, 4, 5: return CAP_W'($urandom);
            default:    return CAP_W'($urandom_range(0, board.capacity));
        endcase
    endfunction

    // One register setting per random phase; some phases force the span cases
    task automatic random_phase_config(input int phase);
        logic [MV_W-1:0]    rated;
        logic [MV_W-1:0]    discharge;
        logic [CELLS_W-1:0] cells;
        logic [CAP_W-1:0]   cap;
        discharge = MV_W'($urandom_range(2500, 3400));
        rated     = MV_W'($urandom_range(3600, 4500));
        case (phase)
            1: rated = discharge;                                    // zero span
            2: begin                                                 // rated below empty
                discharge = MV_W'($urandom_range(3000, 4000));
                rated     = discharge - MV_W'($urandom_range(1, 1000));
            end
            3: begin                                                 // widest span
                rated     = MV_MAX;
                discharge = '0;
            end
            4: rated = discharge + 1'b1;                             // one millivolt span
            5: begin
                rated     = MV_W'($urandom);
                discharge = MV_W'($urandom);
            end
            default: ;
        endcase
        cells = (phase == 0) ? CELLS_W'(MAX_CELLS) : CELLS_W'($urandom_range(0, CELLS_TOP));
        case ($urandom_range(0, 3))
            0:       cap = '0;
            1:       cap = CAP_MAX;
            default: cap = CAP_W'($urandom);
        endcase
        set_config(rated, discharge, cells, cap);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [MV_W-1:0] mv;
        cell_bus.valid        = 1'b0;
        cell_bus.cell_mv      = '0;
        cell_bus.remaining_in = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = REG_RATED_MV;
        cfg_bus.data          = '0;
        src_idling            = 1'b1;
        sink_idling           = 1'b1;
        hold_asked            = 1'b0;
        rst_n                 = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings, capacity zero: the last cell clears what remains.
        // Half level, exactly empty, exactly full, then zero volts.
        send_cell(16'd3600, CAP_MAX);
        send_cell(16'd3000, '0);
        send_cell(16'd4200, 24'd123456);
        send_cell(16'd0, CAP_MAX);

        // No cell under 200 percent: the first cell carries the pack.
        // Four spans exactly, full-scale voltage and one past four spans.
        set_config(RATED_RST, DISCHARGE_RST, CELLS_RST, 24'd1000);
        send_cell(16'd5000, CAP_MAX);
        send_cell(16'd7800, CAP_MAX);
        send_cell(MV_MAX, CAP_MAX);
        send_cell(16'd7801, CAP_MAX);

        // Equal lows: the earlier one stands
        send_cell(16'd3600, CAP_MAX);
        send_cell(16'd3600, CAP_MAX);
        send_cell(16'd4200, CAP_MAX);
        send_cell(16'd3600, CAP_MAX);

        // Single-cell pack, then a count of zero taken as one
        set_config(RATED_RST, DISCHARGE_RST, 3'd1, CAP_MAX);
        send_cell(16'd3300, CAP_MAX);
        set_config(RATED_RST, DISCHARGE_RST, '0, CAP_MAX);
        send_cell(16'd2999, CAP_MAX);

        // Zero span: empty stays at zero, anything above saturates
        set_config(16'd3000, 16'd3000, '0, CAP_MAX);
        send_cell(16'd3000, CAP_MAX);
        send_cell(16'd3001, CAP_MAX);

        // Rated below empty: every level floors at zero
        set_config(16'd3000, 16'd4000, '0, CAP_MAX);
        send_cell(16'd4500, CAP_MAX);
        send_cell(16'd3500, CAP_MAX);

        // Count above the build limit, clamped to a four-cell scan
        set_config(RATED_RST, DISCHARGE_RST, CELLS_TOP, CAP_MAX);
        send_cell(16'd4199, CAP_MAX);
        send_cell(16'd3001, 24'd5000000);
        send_cell(16'd4000, CAP_MAX);
        send_cell(16'd3200, CAP_MAX);

        // Lower the count once the scan is already past it: the next beat
        // closes the pack
        send_cell(16'd3900, CAP_MAX);
        send_cell(16'd3100, CAP_MAX);
        send_cell(16'd3700, CAP_MAX);
        drain_results();
        cfg_write(REG_CELLS_IN_PACK, CFG_DATA_W'(2));
        send_cell(16'd3400, CAP_MAX);

        // Random phases; the last two run with no idling on either side
        for (int phase = 0; phase < PHASES; phase++)
        begin
            random_phase_config(phase);
            src_idling  = (phase < PHASES - 2) && (phase == 0 || $urandom_range(0, 3) != 0);
            sink_idling = (phase < PHASES - 2) && (phase == 0 || $urandom_range(0, 3) != 0);
            mv = board.discharge_mv;
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // ask for the long result hold-off and keep offering beats
                if (phase == 2 && n == 10)
                    hold_asked <= 1'b1;
                mv = pick_mv(mv);
                send_cell(mv, pick_remaining());
            end
        end

        while (board.owed.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ccce_pkg.sv
rtl/ccce_if.sv
rtl/ccce_mul.sv
rtl/ccce_div.sv
rtl/cell_charge_curve_estimator_core.sv
tb/tb.sv
